// ----- rtl/tclc_pkg.sv -----
package tclc_pkg;

  localparam int CNT_W = 16;
  localparam int LUX_W = 27;
  localparam int POW_W = 16;
  localparam int K_W   = 20;
  localparam int PROD_W = 52;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  localparam logic [K_W-1:0] K_LOW_A = 20'd510027;
  localparam logic [K_W-1:0] K_LOW_B = 20'd1040187;
  localparam logic [K_W-1:0] K_B2_A  = 20'd375810;
  localparam logic [K_W-1:0] K_B2_B  = 20'd520094;
  localparam logic [K_W-1:0] K_B3_A  = 20'd214748;
  localparam logic [K_W-1:0] K_B3_B  = 20'd256691;
  localparam logic [K_W-1:0] K_B4_A  = 20'd24495;
  localparam logic [K_W-1:0] K_B4_B  = 20'd18790;

  typedef enum logic [2:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH,
    BAND_TOP,
    BAND_NONE
  } band_e;

  typedef struct packed {
    logic [CNT_W-1:0] broadband_count;
    logic [CNT_W-1:0] infrared_count;
  } in_t;

  typedef struct packed {
    logic [LUX_W-1:0] lux_value;
    logic             invalid;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] c0;
    logic [CNT_W-1:0] c1;
    band_e            band;
    logic             invalid;
  } stage_t;

endpackage

// ----- rtl/tclc_front.sv -----
module tclc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  tclc_pkg::in_t    item_i,
  output logic             vld_o,
  output tclc_pkg::stage_t item_o
);

  logic             vld_q;
  tclc_pkg::stage_t item_d;
  tclc_pkg::stage_t item_q;
  logic [16:0]      c1_x2;
  logic [22:0]      c1_x100;
  logic [22:0]      c0_x61;
  logic [18:0]      c1_x5;
  logic [18:0]      c0_x4;
  logic [19:0]      c1_x10;
  logic [19:0]      c0_x13;

  assign c1_x2   = {item_i.infrared_count, 1'b0};
  assign c1_x100 = 23'(item_i.infrared_count) * 23'd100;
  assign c0_x61  = 23'(item_i.broadband_count) * 23'd61;
  assign c1_x5   = 19'(item_i.infrared_count) * 19'd5;
  assign c0_x4   = {1'b0, item_i.broadband_count, 2'b00};
  assign c1_x10  = 20'(item_i.infrared_count) * 20'd10;
  assign c0_x13  = 20'(item_i.broadband_count) * 20'd13;

  always_comb begin
    item_d.c0      = item_i.broadband_count;
    item_d.c1      = item_i.infrared_count;
    item_d.invalid = (item_i.infrared_count == '0);
    if (item_d.invalid) begin
      item_d.band = tclc_pkg::BAND_NONE;
    end else if (c1_x2 <= {1'b0, item_i.broadband_count}) begin
      item_d.band = tclc_pkg::BAND_LOW;
    end else if (c1_x100 <= c0_x61) begin
      item_d.band = tclc_pkg::BAND_MID;
    end else if (c1_x5 <= c0_x4) begin
      item_d.band = tclc_pkg::BAND_HIGH;
    end else if (c1_x10 <= c0_x13) begin
      item_d.band = tclc_pkg::BAND_TOP;
    end else begin
      item_d.band = tclc_pkg::BAND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ----- rtl/tclc_div.sv -----
module tclc_div #(
  parameter int RATIO_FRAC_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  tclc_pkg::stage_t           item_i,
  output logic                       vld_o,
  output tclc_pkg::stage_t           item_o,
  output logic [RATIO_FRAC_BITS-1:0] idx_o
);

  localparam int R = RATIO_FRAC_BITS;

  logic [R-1:0]            vld_q;
  logic [15:0]             rem_q  [R];
  logic [R-1:0]            quo_q  [R];
  tclc_pkg::stage_t        item_q [R];

  genvar k;
  for (k = 0; k < R; k++) begin : g_stage
    logic             vld_in;
    logic [15:0]      rem_in;
    logic [R-1:0]     quo_in;
    tclc_pkg::stage_t item_in;
    logic [16:0]      shl;
    logic [16:0]      sub;
    logic             take;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = item_i.c1;
      assign quo_in  = '0;
      assign item_in = item_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign item_in = item_q[k-1];
    end

    assign shl  = {rem_in, 1'b0};
    assign sub  = shl - {1'b0, item_in.c0};
    assign take = (shl >= {1'b0, item_in.c0});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? sub[15:0] : shl[15:0];
      quo_q[k]  <= {quo_in[R-2:0], take};
      item_q[k] <= item_in;
    end
  end

  assign vld_o  = vld_q[R-1];
  assign item_o = item_q[R-1];
  assign idx_o  = quo_q[R-1];

endmodule

// ----- rtl/tclc_rom.sv -----
module tclc_rom #(
  parameter int RATIO_FRAC_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  tclc_pkg::stage_t           item_i,
  input  logic [RATIO_FRAC_BITS-1:0] idx_i,
  output logic                       vld_o,
  output tclc_pkg::stage_t           item_o,
  output logic [tclc_pkg::POW_W-1:0] pow_o
);

  localparam int R        = RATIO_FRAC_BITS;
  localparam int TableLen = (1 << (R - 1)) + 1;
  localparam logic [R-1:0] LastIdx = R'(TableLen - 1);

  typedef logic [tclc_pkg::POW_W-1:0] rom_t [TableLen];

  function automatic rom_t build_rom();
    rom_t         tab;
    logic [127:0] rhs;
    logic [127:0] lhs;
    int           lo;
    int           hi;
    int           mid;
    int           s;
    int           i;
    int           j;
    s = 7 * R - 85;
    for (i = 0; i < TableLen; i++) begin
      rhs = 128'd1;
      for (j = 0; j < 7; j++) begin
        rhs = rhs * 128'(i);
      end
      if (s < 0) begin
        rhs = rhs << (-s);
      end
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = 128'd1;
        for (j = 0; j < 5; j++) begin
          lhs = lhs * 128'(2 * mid - 1);
        end
        if (s > 0) begin
          lhs = lhs << s;
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      tab[i] = tclc_pkg::POW_W'(lo);
    end
    return tab;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [R-1:0]                 idx_c;
  logic                         vld_q;
  tclc_pkg::stage_t             item_q;
  logic [tclc_pkg::POW_W-1:0]   pow_q;

  assign idx_c = (idx_i > LastIdx) ? LastIdx : idx_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
    pow_q  <= Rom[idx_c];
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;
  assign pow_o  = pow_q;

endmodule

// ----- rtl/tclc_mac.sv -----
module tclc_mac #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  tclc_pkg::stage_t           item_i,
  input  logic [tclc_pkg::POW_W-1:0] pow_i,
  output logic                       done_o,
  output tclc_pkg::out_t             result_o
);

  localparam int Shift = 40 - OUT_FRAC_BITS;
  localparam int PW    = tclc_pkg::PROD_W;
  localparam int MW    = tclc_pkg::K_W + tclc_pkg::CNT_W;

  logic [tclc_pkg::K_W-1:0] ka;
  logic [tclc_pkg::K_W-1:0] kb;

  always_comb begin
    unique case (item_i.band)
      tclc_pkg::BAND_LOW: begin
        ka = tclc_pkg::K_LOW_A;
        kb = '0;
      end
      tclc_pkg::BAND_MID: begin
        ka = tclc_pkg::K_B2_A;
        kb = tclc_pkg::K_B2_B;
      end
      tclc_pkg::BAND_HIGH: begin
        ka = tclc_pkg::K_B3_A;
        kb = tclc_pkg::K_B3_B;
      end
      tclc_pkg::BAND_TOP: begin
        ka = tclc_pkg::K_B4_A;
        kb = tclc_pkg::K_B4_B;
      end
      default: begin
        ka = '0;
        kb = '0;
      end
    endcase
  end

  logic          v1_q;
  logic          low1_q;
  logic          none1_q;
  logic          inv1_q;
  logic [MW-1:0] posm_q;
  logic [MW-1:0] negm_q;
  logic [31:0]   cp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    low1_q  <= (item_i.band == tclc_pkg::BAND_LOW);
    none1_q <= (item_i.band == tclc_pkg::BAND_NONE);
    inv1_q  <= item_i.invalid;
    posm_q  <= MW'(ka) * MW'(item_i.c0);
    negm_q  <= MW'(kb) * MW'(item_i.c1);
    cp_q    <= 32'(item_i.c1) * 32'(pow_i);
  end

  logic          v2_q;
  logic          none2_q;
  logic          inv2_q;
  logic [PW-1:0] pos_d;
  logic [PW-1:0] neg_d;
  logic [PW-1:0] pos_q;
  logic [PW-1:0] neg_q;

  assign pos_d = {posm_q, 16'b0};
  assign neg_d = low1_q ? (PW'(tclc_pkg::K_LOW_B) * PW'(cp_q)) : {negm_q, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    none2_q <= none1_q;
    inv2_q  <= inv1_q;
    pos_q   <= pos_d;
    neg_q   <= neg_d;
  end

  logic                       v3_q;
  logic [PW-1:0]              diff;
  logic [PW-1:0]              scaled;
  tclc_pkg::out_t             res_d;
  tclc_pkg::out_t             res_q;

  assign diff   = pos_q - neg_q;
  assign scaled = diff >> Shift;

  always_comb begin
    res_d.invalid = inv2_q;
    if (none2_q || (pos_q <= neg_q)) begin
      res_d.lux_value = '0;
    end else if (scaled > PW'(tclc_pkg::LUX_MAX)) begin
      res_d.lux_value = tclc_pkg::LUX_MAX;
    end else begin
      res_d.lux_value = scaled[tclc_pkg::LUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = v3_q;
  assign result_o = res_q;

endmodule

// ----- rtl/two_channel_lux_calculator.sv -----
// Pipeline from start to done_o: front-end band select, ratio divider, ROM lookup, then the MAC registers.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the ratio divider, which resolves one quotient bit per stage.
// Reset clears all valid bits at once; results appear for one cycle on done_o.
module two_channel_lux_calculator #(
  parameter int RATIO_FRAC_BITS = 10,
  parameter int OUT_FRAC_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tclc_pkg::in_t  item_i,
  output logic           done_o,
  output tclc_pkg::out_t result_o
);

  logic                       accept;
  logic                       f_vld;
  tclc_pkg::stage_t           f_item;
  logic                       d_vld;
  tclc_pkg::stage_t           d_item;
  logic [RATIO_FRAC_BITS-1:0] d_idx;
  logic                       r_vld;
  tclc_pkg::stage_t           r_item;
  logic [tclc_pkg::POW_W-1:0] r_pow;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  tclc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .vld_o    (f_vld),
    .item_o   (f_item)
  );

  tclc_div #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f_vld),
    .item_i (f_item),
    .vld_o  (d_vld),
    .item_o (d_item),
    .idx_o  (d_idx)
  );

  tclc_rom #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d_vld),
    .item_i (d_item),
    .idx_i  (d_idx),
    .vld_o  (r_vld),
    .item_o (r_item),
    .pow_o  (r_pow)
  );

  tclc_mac #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (r_vld),
    .item_i   (r_item),
    .pow_i    (r_pow),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
